[design/ps2kmc_pkg.sv]
package ps2kmc_pkg;

  localparam int FIFO_DEPTH_DEF  = 16;
  localparam int REPLY_DEPTH_DEF = 4;
  localparam int DIV_STEPS       = 24;

  typedef enum logic [1:0] {
    CFG_TYP_DELAY  = 2'd0,
    CFG_TYP_PERIOD = 2'd1,
    CFG_REPLY_DLY  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_RD_DATA   = 3'd0,
    OP_RD_STATUS = 3'd1,
    OP_WR_DATA   = 3'd2,
    OP_WR_CMD    = 3'd3,
    OP_TICK      = 3'd4,
    OP_SCAN      = 3'd5,
    OP_MOUSE     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ORG_KBD = 2'd0,
    ORG_AUX = 2'd1,
    ORG_CTL = 2'd2
  } org_t;

  typedef enum logic [2:0] {
    PW_NONE    = 3'd0,
    PW_CMDBYTE = 3'd1,
    PW_OUTPORT = 3'd2,
    PW_LEDS    = 3'd3,
    PW_RATE    = 3'd4,
    PW_SET     = 3'd5,
    PW_AUX     = 3'd6
  } pw_t;

  typedef enum logic [1:0] {
    MP_NONE = 2'd0,
    MP_RATE = 2'd1,
    MP_RES  = 2'd2
  } mp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_RELEASE,
    ST_REP_FIRST,
    ST_DIV_START,
    ST_DIVIDE,
    ST_REP_MORE,
    ST_SETTLE,
    ST_IRQ
  } state_t;

  typedef enum logic [1:0] {
    STG_JOB,
    STG_REL,
    STG_REPF,
    STG_REPN
  } stage_t;

  localparam logic [7:0] BYTE_ACK    = 8'hFA;
  localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
  localparam logic [7:0] BYTE_ID1    = 8'hAB;
  localparam logic [7:0] BYTE_ID2    = 8'h83;
  localparam logic [7:0] BYTE_RESEND = 8'hFE;
  localparam logic [7:0] BYTE_ECHO   = 8'hEE;
  localparam logic [7:0] BYTE_SELFOK = 8'h55;

  localparam logic [7:0] KC_RESET    = 8'hFF;
  localparam logic [7:0] KC_LEDS     = 8'hED;
  localparam logic [7:0] KC_ECHO     = 8'hEE;
  localparam logic [7:0] KC_SET      = 8'hF0;
  localparam logic [7:0] KC_RATE     = 8'hF3;
  localparam logic [7:0] KC_ENABLE   = 8'hF4;
  localparam logic [7:0] KC_DISABLE  = 8'hF5;
  localparam logic [7:0] KC_DEFAULTS = 8'hF6;
  localparam logic [7:0] KC_IDENT    = 8'hF2;
  localparam logic [7:0] KC_RESEND   = 8'hFE;

  localparam logic [7:0] MC_RESET    = 8'hFF;
  localparam logic [7:0] MC_DEFAULTS = 8'hF6;
  localparam logic [7:0] MC_DISABLE  = 8'hF5;
  localparam logic [7:0] MC_ENABLE   = 8'hF4;
  localparam logic [7:0] MC_IDENT    = 8'hF2;
  localparam logic [7:0] MC_RATE     = 8'hF3;
  localparam logic [7:0] MC_RES      = 8'hE8;
  localparam logic [7:0] MC_STATUS   = 8'hE9;

  localparam logic [7:0] CC_RD_CB    = 8'h20;
  localparam logic [7:0] CC_WR_CB    = 8'h60;
  localparam logic [7:0] CC_SELFTEST = 8'hAA;
  localparam logic [7:0] CC_KTEST    = 8'hAB;
  localparam logic [7:0] CC_KBD_OFF  = 8'hAD;
  localparam logic [7:0] CC_KBD_ON   = 8'hAE;
  localparam logic [7:0] CC_AUX_OFF  = 8'hA7;
  localparam logic [7:0] CC_AUX_ON   = 8'hA8;
  localparam logic [7:0] CC_ATEST    = 8'hA9;
  localparam logic [7:0] CC_RD_OUTP  = 8'hD0;
  localparam logic [7:0] CC_WR_OUTP  = 8'hD1;
  localparam logic [7:0] CC_WR_AUX   = 8'hD4;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         data_byte;
    logic [23:0]        tick_count;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [2:0]         buttons;
  } ps2kmc_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       result_status;
    logic       irq1_level;
    logic       irq12_level;
    logic       a20_enable;
    logic       cpu_reset_request;
  } ps2kmc_out_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic push;
    logic release_chk;
    logic rep_first;
    logic div_start;
    logic div_step;
    logic rep_more;
    logic finish;
  } ps2kmc_cmd_t;

  typedef struct packed {
    logic push_done;
    logic rep_go;
    logic per_zero;
    logic div_done;
    logic out_free;
  } ps2kmc_stat_t;

endpackage

[design/ps2kmc_ctrl.sv]
module ps2kmc_ctrl
  import ps2kmc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  ps2kmc_stat_t stat,
  output ps2kmc_cmd_t  cmd
);

  state_t state, state_next;
  stage_t stage, stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= STG_JOB;
    end else begin
      state <= state_next;
      stage <= stage_next;
    end
  end

  always_comb begin
    state_next = state;
    stage_next = stage;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_PUSH;
        stage_next = STG_JOB;
      end
      ST_PUSH: begin
        if (stat.push_done) begin
          unique case (stage)
            STG_JOB:  state_next = ST_RELEASE;
            STG_REL:  state_next = ST_REP_FIRST;
            STG_REPF: state_next = ST_DIV_START;
            STG_REPN: state_next = ST_SETTLE;
            default:  state_next = ST_SETTLE;
          endcase
        end
      end
      ST_RELEASE: begin
        state_next = ST_PUSH;
        stage_next = STG_REL;
      end
      ST_REP_FIRST: begin
        if (stat.rep_go) begin
          state_next = ST_PUSH;
          stage_next = STG_REPF;
        end else begin
          state_next = ST_SETTLE;
        end
      end
      ST_DIV_START: begin
        state_next = stat.per_zero ? ST_SETTLE : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.div_done) state_next = ST_REP_MORE;
      end
      ST_REP_MORE: begin
        state_next = ST_PUSH;
        stage_next = STG_REPN;
      end
      ST_SETTLE: begin
        state_next = ST_IRQ;
      end
      ST_IRQ: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    in_stall        = (state != ST_IDLE);
    cmd.take        = (state == ST_IDLE) && in_valid;
    cmd.exec        = (state == ST_EXEC);
    cmd.push        = (state == ST_PUSH);
    cmd.release_chk = (state == ST_RELEASE);
    cmd.rep_first   = (state == ST_REP_FIRST);
    cmd.div_start   = (state == ST_DIV_START);
    cmd.div_step    = (state == ST_DIVIDE);
    cmd.rep_more    = (state == ST_REP_MORE);
    cmd.finish      = (state == ST_IRQ);
  end

endmodule

[design/ps2kmc_dp.sv]
module ps2kmc_dp
  import ps2kmc_pkg::*;
#(
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
  parameter int REPLY_DEPTH = REPLY_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  input  ps2kmc_in_t   in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output ps2kmc_out_t  out_data,
  input  ps2kmc_cmd_t  cmd,
  output ps2kmc_stat_t stat
);

  localparam int AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW  = $clog2(FIFO_DEPTH + 1);
  localparam int RW  = $clog2(REPLY_DEPTH);
  localparam int RLW = $clog2(REPLY_DEPTH + 1);
  localparam int DCW = $clog2(DIV_STEPS + 1);

  logic [23:0] typ_delay, typ_period, reply_delay;

  logic [7:0] fifo_data [FIFO_DEPTH];
  org_t       fifo_org  [FIFO_DEPTH];
  logic [7:0] head_data;
  org_t       head_org;
  logic [AW-1:0] head_ptr, tail_ptr;
  logic [FW-1:0] fill;

  logic [7:0]     reply_buf [REPLY_DEPTH];
  logic [RLW-1:0] reply_len;
  org_t           reply_org;
  logic [23:0]    reply_wait;
  logic           rel_go;

  logic [7:0] cb, outport;
  pw_t        pw;
  logic       scan_on;
  logic       rep_on;
  logic [23:0] rep_cd;
  logic [7:0] rep_code;
  logic       rep_go;
  logic [23:0] el2;
  logic       m_rep;
  logic [2:0] m_btn;
  logic [7:0] m_res, m_rate;
  mp_t        m_await;
  logic       irq1, irq12, irq_pend;
  logic [7:0] last;

  ps2kmc_in_t item;
  logic [7:0] rd_r;
  logic       refused_r, pulse_r;

  logic [7:0]    pbuf [REPLY_DEPTH];
  logic [RW-1:0] pidx;
  logic [FW-1:0] pcnt;
  org_t          porg;
  logic          prep;

  logic [23:0]    div_rem, div_quo;
  logic [DCW-1:0] div_cnt;
  logic [24:0]    div_trial;

  logic push_we;
  logic irq1_new, irq12_new;
  logic kbd_on, aux_on;

  logic [7:0]  cb_n, outport_n, rep_code_n, m_res_n, m_rate_n, rd_n;
  pw_t         pw_n;
  mp_t         m_await_n;
  logic        scan_on_n, rep_on_n, m_rep_n, irq1_n, irq12_n, irq_pend_n;
  logic        refused_n, pulse_n, pop_n, rep_go_n, rel_go_tick;
  logic [2:0]  m_btn_n;
  logic [23:0] rep_cd_n, el2_n, wait_n;
  logic        post_req;
  logic [RLW-1:0] post_n;
  logic [3:0][7:0] post_b;
  org_t        post_org;
  logic [1:0]  job_cnt;
  logic [2:0][7:0] job_b;
  org_t        job_org;
  logic        x_ovf, x_neg, y_ovf, y_neg;
  logic [7:0]  x_b, y_b;

  function automatic logic repeats(input logic [7:0] c);
    logic r;
    r = !(c == 8'h1D || c == 8'h2A || c == 8'h36 || c == 8'h38 ||
          c == 8'h3A || c == 8'h45 || c == 8'h46 || c == 8'hE0 || c == 8'hE1);
    return r;
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  assign kbd_on = !cb[4];
  assign aux_on = !cb[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      typ_delay   <= '0;
      typ_period  <= '0;
      reply_delay <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TYP_DELAY:  typ_delay   <= cfg_data;
        CFG_TYP_PERIOD: typ_period  <= cfg_data;
        CFG_REPLY_DLY:  reply_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  assign push_we = cmd.push && (pcnt != '0) && (fill != FW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push_we) begin
      fifo_data[tail_ptr] <= pbuf[pidx];
      fifo_org[tail_ptr]  <= porg;
    end
    head_data <= fifo_data[head_ptr];
    head_org  <= fifo_org[head_ptr];
  end

  always_comb begin
    x_ovf = 1'b0;
    x_neg = 1'b0;
    x_b   = item.delta_x[7:0];
    if (item.delta_x > 16'sd255) begin
      x_ovf = 1'b1;
      x_b   = 8'hFF;
    end else if (item.delta_x < -16'sd256) begin
      x_ovf = 1'b1;
      x_neg = 1'b1;
      x_b   = 8'h00;
    end else begin
      x_neg = item.delta_x[15];
    end
    y_ovf = 1'b0;
    y_neg = 1'b0;
    y_b   = item.delta_y[7:0];
    if (item.delta_y > 16'sd255) begin
      y_ovf = 1'b1;
      y_b   = 8'hFF;
    end else if (item.delta_y < -16'sd256) begin
      y_ovf = 1'b1;
      y_neg = 1'b1;
      y_b   = 8'h00;
    end else begin
      y_neg = item.delta_y[15];
    end
  end

  always_comb begin
    cb_n        = cb;
    outport_n   = outport;
    pw_n        = pw;
    scan_on_n   = scan_on;
    rep_on_n    = rep_on;
    rep_cd_n    = rep_cd;
    rep_code_n  = rep_code;
    m_rep_n     = m_rep;
    m_btn_n     = m_btn;
    m_res_n     = m_res;
    m_rate_n    = m_rate;
    m_await_n   = m_await;
    irq1_n      = irq1;
    irq12_n     = irq12;
    irq_pend_n  = 1'b0;
    rd_n        = 8'h00;
    refused_n   = 1'b0;
    pulse_n     = 1'b0;
    pop_n       = 1'b0;
    rep_go_n    = 1'b0;
    rel_go_tick = 1'b0;
    el2_n       = '0;
    wait_n      = reply_wait;
    post_req    = 1'b0;
    post_n      = RLW'(1);
    post_b      = '0;
    post_org    = ORG_KBD;
    job_cnt     = 2'd0;
    job_b       = '0;
    job_org     = ORG_KBD;
    unique case (op_t'(item.op))
      OP_RD_DATA: begin
        if (fill != '0) begin
          rd_n       = head_data;
          pop_n      = 1'b1;
          irq_pend_n = 1'b1;
          if (head_org == ORG_KBD) irq1_n = 1'b0;
          else if (head_org == ORG_AUX) irq12_n = 1'b0;
        end
      end
      OP_RD_STATUS: begin
        rd_n = {2'b00, (fill != '0) && (head_org == ORG_AUX), kbd_on,
                1'b0, 1'b1, 1'b0, fill != '0};
      end
      OP_WR_DATA: begin
        unique case (pw)
          PW_CMDBYTE: begin
            cb_n       = item.data_byte;
            pw_n       = PW_NONE;
            irq_pend_n = 1'b1;
          end
          PW_OUTPORT: begin
            outport_n = item.data_byte;
            pw_n      = PW_NONE;
            pulse_n   = !item.data_byte[0];
          end
          PW_LEDS, PW_RATE: begin
            pw_n      = PW_NONE;
            post_req  = 1'b1;
            post_b[0] = BYTE_ACK;
          end
          PW_SET: begin
            pw_n     = PW_NONE;
            post_req = 1'b1;
            if (item.data_byte == 8'h00) begin
              post_n    = RLW'(2);
              post_b[0] = BYTE_ACK;
              post_b[1] = 8'h01;
            end else if (item.data_byte == 8'h01) begin
              post_b[0] = BYTE_ACK;
            end else begin
              post_b[0] = BYTE_RESEND;
            end
          end
          PW_AUX: begin
            pw_n     = PW_NONE;
            post_req = 1'b1;
            post_org = ORG_AUX;
            post_b[0] = BYTE_ACK;
            if (m_await == MP_RATE) begin
              m_await_n = MP_NONE;
              if (item.data_byte == 8'd10 || item.data_byte == 8'd20 ||
                  item.data_byte == 8'd40 || item.data_byte == 8'd60 ||
                  item.data_byte == 8'd80 || item.data_byte == 8'd100 ||
                  item.data_byte == 8'd200) begin
                m_rate_n = item.data_byte;
              end else begin
                post_b[0] = BYTE_RESEND;
              end
            end else if (m_await == MP_RES) begin
              m_await_n = MP_NONE;
              if (item.data_byte <= 8'd3) m_res_n = item.data_byte;
              else post_b[0] = BYTE_RESEND;
            end else begin
              unique case (item.data_byte)
                MC_RESET: begin
                  m_rep_n   = 1'b0;
                  m_btn_n   = 3'd0;
                  m_res_n   = 8'd2;
                  m_rate_n  = 8'd100;
                  m_await_n = MP_NONE;
                  post_n    = RLW'(3);
                  post_b[1] = BYTE_BAT_OK;
                end
                MC_DEFAULTS: begin
                  m_rep_n   = 1'b0;
                  m_btn_n   = 3'd0;
                  m_res_n   = 8'd2;
                  m_rate_n  = 8'd100;
                  m_await_n = MP_NONE;
                end
                MC_DISABLE: m_rep_n = 1'b0;
                MC_ENABLE:  m_rep_n = 1'b1;
                MC_IDENT:   post_n = RLW'(2);
                MC_RATE:    m_await_n = MP_RATE;
                MC_RES:     m_await_n = MP_RES;
                MC_STATUS: begin
                  post_n    = RLW'(4);
                  post_b[1] = {2'b00, m_rep, 2'b00, m_btn};
                  post_b[2] = m_res;
                  post_b[3] = m_rate;
                end
                default: post_b[0] = BYTE_RESEND;
              endcase
            end
          end
          default: begin
            post_req  = 1'b1;
            post_b[0] = BYTE_ACK;
            unique case (item.data_byte)
              KC_RESET: begin
                post_n    = RLW'(2);
                post_b[1] = BYTE_BAT_OK;
                scan_on_n = 1'b1;
                rep_on_n  = 1'b0;
                rep_cd_n  = '0;
              end
              KC_LEDS:  pw_n = PW_LEDS;
              KC_ECHO:  post_b[0] = BYTE_ECHO;
              KC_SET:   pw_n = PW_SET;
              KC_RATE:  pw_n = PW_RATE;
              KC_ENABLE: scan_on_n = 1'b1;
              KC_DISABLE: begin
                scan_on_n = 1'b0;
                rep_on_n  = 1'b0;
              end
              KC_DEFAULTS: begin
                scan_on_n = 1'b1;
                rep_on_n  = 1'b0;
                rep_cd_n  = '0;
              end
              KC_IDENT: begin
                post_n    = RLW'(3);
                post_b[1] = BYTE_ID1;
                post_b[2] = BYTE_ID2;
              end
              KC_RESEND: post_b[0] = last;
              default:   post_b[0] = BYTE_RESEND;
            endcase
          end
        endcase
      end
      OP_WR_CMD: begin
        post_org = ORG_CTL;
        unique case (item.data_byte)
          CC_RD_CB: begin
            post_req  = 1'b1;
            post_b[0] = cb;
          end
          CC_WR_CB: pw_n = PW_CMDBYTE;
          CC_SELFTEST: begin
            post_req  = 1'b1;
            post_b[0] = BYTE_SELFOK;
          end
          CC_KTEST, CC_ATEST: post_req = 1'b1;
          CC_KBD_OFF: begin
            cb_n       = cb | 8'h10;
            irq_pend_n = 1'b1;
          end
          CC_KBD_ON: begin
            cb_n       = cb & 8'hEF;
            irq_pend_n = 1'b1;
          end
          CC_AUX_OFF: begin
            cb_n       = cb | 8'h20;
            irq_pend_n = 1'b1;
          end
          CC_AUX_ON: begin
            cb_n       = cb & 8'hDF;
            irq_pend_n = 1'b1;
          end
          CC_RD_OUTP: begin
            post_req  = 1'b1;
            post_b[0] = outport;
          end
          CC_WR_OUTP: pw_n = PW_OUTPORT;
          CC_WR_AUX:  pw_n = PW_AUX;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (reply_len != '0) begin
          if (item.tick_count < reply_wait) begin
            wait_n = reply_wait - item.tick_count;
          end else begin
            wait_n      = '0;
            rel_go_tick = 1'b1;
          end
        end
        if (item.tick_count != '0 && rep_on) begin
          if (item.tick_count < rep_cd) begin
            rep_cd_n = rep_cd - item.tick_count;
          end else begin
            el2_n    = item.tick_count - rep_cd;
            rep_go_n = 1'b1;
          end
        end
      end
      OP_SCAN: begin
        if (!kbd_on || !scan_on) begin
          refused_n = 1'b1;
        end else begin
          if (item.data_byte[7] && ({1'b0, item.data_byte[6:0]} == rep_code)) begin
            rep_on_n = 1'b0;
          end else if (typ_delay != '0 && typ_period != '0 && !item.data_byte[7] &&
                       repeats(item.data_byte)) begin
            rep_code_n = item.data_byte;
            rep_cd_n   = typ_delay;
            rep_on_n   = 1'b1;
          end
          if (fill == FW'(FIFO_DEPTH)) begin
            refused_n = 1'b1;
          end else begin
            job_cnt  = 2'd1;
            job_b[0] = item.data_byte;
          end
        end
      end
      OP_MOUSE: begin
        if (!aux_on || !m_rep) begin
          refused_n = 1'b1;
        end else if (item.delta_x == '0 && item.delta_y == '0 && item.buttons == m_btn) begin
          refused_n = 1'b0;
        end else if (reply_len != '0 || (32'(fill) + 32'd3) > 32'(FIFO_DEPTH)) begin
          refused_n = 1'b1;
        end else begin
          job_cnt  = 2'd3;
          job_org  = ORG_AUX;
          job_b[0] = {y_ovf, x_ovf, y_neg, x_neg, 1'b1, item.buttons};
          job_b[1] = x_b;
          job_b[2] = y_b;
          m_btn_n  = item.buttons;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    irq1_new  = irq1;
    irq12_new = irq12;
    if (irq_pend) begin
      if (fill == '0) begin
        irq1_new  = 1'b0;
        irq12_new = 1'b0;
      end else begin
        unique case (head_org)
          ORG_KBD: begin
            irq12_new = 1'b0;
            if (kbd_on && cb[0]) irq1_new = 1'b1;
          end
          ORG_AUX: begin
            irq1_new = 1'b0;
            if (aux_on && cb[1]) irq12_new = 1'b1;
          end
          default: begin
            irq1_new  = 1'b0;
            irq12_new = 1'b0;
          end
        endcase
      end
    end
  end

  assign div_trial = {div_rem, div_quo[23]};

  always_ff @(posedge clk) begin
    if (cmd.take) item <= in_data;
    if (cmd.exec) begin
      rd_r      <= rd_n;
      refused_r <= refused_n;
      pulse_r   <= pulse_n;
      el2       <= el2_n;
      if (post_req && reply_len == '0) begin
        for (int i = 0; i < 4; i++) reply_buf[i] <= post_b[i];
        reply_org <= post_org;
      end
      for (int i = 0; i < 3; i++) pbuf[i] <= job_b[i];
      porg <= job_org;
    end
    if (cmd.release_chk && rel_go &&
        (32'(reply_len) + 32'(fill)) <= 32'(FIFO_DEPTH)) begin
      for (int i = 0; i < REPLY_DEPTH; i++) pbuf[i] <= reply_buf[i];
      porg <= reply_org;
    end
    if ((cmd.rep_first && rep_go) || cmd.rep_more) begin
      pbuf[0] <= rep_code;
      porg    <= ORG_KBD;
    end
    if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= el2;
    end
    if (cmd.div_step && div_cnt != '0) begin
      if (div_trial >= {1'b0, typ_period}) begin
        div_rem <= 24'(div_trial - {1'b0, typ_period});
        div_quo <= {div_quo[22:0], 1'b1};
      end else begin
        div_rem <= div_trial[23:0];
        div_quo <= {div_quo[22:0], 1'b0};
      end
    end
    if (cmd.finish && stat.out_free) begin
      out_data.read_data         <= rd_r;
      out_data.result_status     <= refused_r;
      out_data.irq1_level        <= irq1_new;
      out_data.irq12_level       <= irq12_new;
      out_data.a20_enable        <= outport[1];
      out_data.cpu_reset_request <= pulse_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr   <= '0;
      tail_ptr   <= '0;
      fill       <= '0;
      reply_len  <= '0;
      reply_wait <= '0;
      rel_go     <= 1'b0;
      cb         <= 8'h07;
      outport    <= 8'h01;
      pw         <= PW_NONE;
      scan_on    <= 1'b1;
      rep_on     <= 1'b0;
      rep_cd     <= '0;
      rep_code   <= '0;
      rep_go     <= 1'b0;
      m_rep      <= 1'b0;
      m_btn      <= '0;
      m_res      <= 8'd2;
      m_rate     <= 8'd100;
      m_await    <= MP_NONE;
      irq1       <= 1'b0;
      irq12      <= 1'b0;
      irq_pend   <= 1'b0;
      last       <= '0;
      pidx       <= '0;
      pcnt       <= '0;
      prep       <= 1'b0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        cb       <= cb_n;
        outport  <= outport_n;
        pw       <= pw_n;
        scan_on  <= scan_on_n;
        rep_on   <= rep_on_n;
        rep_cd   <= rep_cd_n;
        rep_code <= rep_code_n;
        rep_go   <= rep_go_n;
        m_rep    <= m_rep_n;
        m_btn    <= m_btn_n;
        m_res    <= m_res_n;
        m_rate   <= m_rate_n;
        m_await  <= m_await_n;
        irq1     <= irq1_n;
        irq12    <= irq12_n;
        irq_pend <= irq_pend_n;
        pidx     <= '0;
        prep     <= 1'b0;
        pcnt     <= FW'(job_cnt);
        if (pop_n) begin
          head_ptr <= wrap_inc(head_ptr);
          fill     <= fill - FW'(1);
        end
        if (post_req && reply_len == '0) begin
          reply_len  <= post_n;
          reply_wait <= reply_delay;
          rel_go     <= (reply_delay == '0);
        end else begin
          reply_wait <= wait_n;
          rel_go     <= rel_go_tick;
        end
      end
      if (cmd.push && pcnt != '0) begin
        pcnt <= pcnt - FW'(1);
        if (!prep) pidx <= pidx + RW'(1);
        if (fill != FW'(FIFO_DEPTH)) begin
          tail_ptr <= wrap_inc(tail_ptr);
          fill     <= fill + FW'(1);
          last     <= pbuf[pidx];
          irq_pend <= 1'b1;
        end
      end
      if (cmd.release_chk) begin
        rel_go <= 1'b0;
        if (rel_go && (32'(reply_len) + 32'(fill)) <= 32'(FIFO_DEPTH)) begin
          pcnt      <= FW'(reply_len);
          pidx      <= '0;
          prep      <= 1'b0;
          reply_len <= '0;
        end
      end
      if (cmd.rep_first && rep_go) begin
        pcnt <= FW'(1);
        pidx <= '0;
        prep <= 1'b1;
      end
      if (cmd.div_start) begin
        if (typ_period == '0) begin
          rep_cd <= '0;
          rep_on <= 1'b0;
        end else begin
          div_cnt <= DCW'(DIV_STEPS);
        end
      end
      if (cmd.div_step && div_cnt != '0) div_cnt <= div_cnt - DCW'(1);
      if (cmd.rep_more) begin
        pcnt   <= (div_quo >= 24'(FIFO_DEPTH)) ? FW'(FIFO_DEPTH) : div_quo[FW-1:0];
        pidx   <= '0;
        prep   <= 1'b1;
        rep_cd <= typ_period - div_rem;
      end
      if (cmd.finish && stat.out_free) begin
        irq1      <= irq1_new;
        irq12     <= irq12_new;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.push_done = (pcnt == '0);
    stat.rep_go    = rep_go;
    stat.per_zero  = (typ_period == '0);
    stat.div_done  = (div_cnt == '0);
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

[design/ps2_keyboard_mouse_controller.sv]
// Channel    Direction  Handshake             Payload
// in         input      in_valid / in_stall   ps2kmc_in_t: one host action
// out        output     out_valid / out_stall ps2kmc_out_t: one result per action
// cfg        input      cfg_wr                cfg_index, cfg_data (24 bits)
//
// An action is taken only while the controller is idle, so the next one is accepted only once
// the result of the last has been registered. Each reply, scan code or packet byte queued into
// the FIFO adds a push step. A tick that fires repeat also runs the divider to count the further
// repeat bytes, which are then pushed; with the period at zero it skips the divider.
// Reset is synchronous and leaves the FIFO and reply buffer empty.
// A stalled result stays in the output register while the next action runs up to its last cycle.
module ps2_keyboard_mouse_controller
  import ps2kmc_pkg::*;
#(
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
  parameter int REPLY_DEPTH = REPLY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  ps2kmc_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ps2kmc_out_t out_data
);

  ps2kmc_cmd_t  cmd;
  ps2kmc_stat_t stat;

  ps2kmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ps2kmc_dp #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .REPLY_DEPTH (REPLY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[sim/ps2_keyboard_mouse_controller_test.sv]
`timescale 1ns / 100ps

module ps2_keyboard_mouse_controller_test;
  import ps2kmc_pkg::*;

  localparam int FDEPTH = FIFO_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr = 1'b0;
  logic [1:0] cfg_index = CFG_TYP_DELAY;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  ps2kmc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ps2kmc_out_t out_data;

  ps2_keyboard_mouse_controller u_dut (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the controller state.
  logic [23:0] typ_delay, typ_period, rep_delay;
  logic [7:0] fifo_data [FDEPTH];
  org_t fifo_org [FDEPTH];
  int unsigned head, fill;
  logic [7:0] rbuf [4];
  int unsigned rlen;
  org_t rorg;
  logic [23:0] rwait;
  logic [7:0] cmd_byte, out_port;
  pw_t pend;
  logic kscan;
  logic [7:0] kset, krate, kleds;
  logic rep_on;
  logic [23:0] rep_count;
  logic [7:0] rep_code;
  logic m_rep;
  logic [2:0] m_btn;
  logic [7:0] m_res, m_rate;
  mp_t m_await;
  logic sys_flag, irq1, irq12;
  logic [7:0] last_byte;
  logic pulse;

  ps2kmc_in_t pending_items[$];
  ps2kmc_out_t expected_results[$];
  int mismatches = 0;
  int transfers_in = 0, transfers_out = 0;
  logic hold_off = 1'b0;

  function automatic logic kbd_en();
    return cmd_byte[4] == 1'b0;
  endfunction

  function automatic logic aux_en();
    return cmd_byte[5] == 1'b0;
  endfunction

  task automatic refresh_irqs();
    org_t s;
    if (fill == 0) begin
      irq1 = 0; irq12 = 0;
      return;
    end
    s = fifo_org[head];
    if (s == ORG_KBD) begin
      irq12 = 0;
      if (kbd_en() && cmd_byte[0]) irq1 = 1;
    end else if (s == ORG_AUX) begin
      irq1 = 0;
      if (aux_en() && cmd_byte[1]) irq12 = 1;
    end else begin
      irq1 = 0; irq12 = 0;
    end
  endtask

  task automatic fifo_push(input logic [7:0] v, input org_t s);
    int unsigned p;
    if (fill >= FDEPTH) return;
    p = (head + fill) % FDEPTH;
    fifo_data[p] = v;
    fifo_org[p] = s;
    fill++;
    last_byte = v;
    refresh_irqs();
  endtask

  task automatic fifo_pop(output logic [7:0] v);
    org_t s;
    v = 8'h00;
    if (fill == 0) return;
    v = fifo_data[head];
    s = fifo_org[head];
    head = (head + 1) % FDEPTH;
    fill--;
    if (s == ORG_KBD) irq1 = 0;
    else if (s == ORG_AUX) irq12 = 0;
    refresh_irqs();
  endtask

  task automatic elapse(input logic [23:0] ticks);
    int unsigned el, n, r;
    el = ticks;
    if (rlen != 0) begin
      if (el < rwait) rwait = rwait - el;
      else begin
        rwait = 0;
        if (rlen <= FDEPTH - fill) begin
          for (int i = 0; i < rlen; i++) fifo_push(rbuf[i], rorg);
          rlen = 0;
        end
      end
    end
    if (el == 0 || !rep_on) return;
    if (el < rep_count) begin
      rep_count = rep_count - el;
      return;
    end
    el = el - rep_count;
    fifo_push(rep_code, ORG_KBD);
    if (typ_period == 0) begin
      rep_count = 0; rep_on = 0;
      return;
    end
    n = el / typ_period;
    r = el % typ_period;
    for (int i = 0; i < n && i < FDEPTH; i++) fifo_push(rep_code, ORG_KBD);
    rep_count = typ_period - r;
  endtask

  task automatic post_reply(input logic [7:0] b0, b1, b2, b3, input int n, input org_t s);
    if (rlen != 0) return;
    rbuf[0] = b0; rbuf[1] = b1; rbuf[2] = b2; rbuf[3] = b3;
    rlen = n;
    rorg = s;
    rwait = rep_delay;
    if (rep_delay == 0) elapse(24'd0);
  endtask

  task automatic kbd_defaults();
    kset = 1; kleds = 0; krate = 8'h20; kscan = 1; rep_on = 0; rep_count = 0;
  endtask

  task automatic mouse_defaults();
    m_rep = 0; m_btn = 0; m_res = 2; m_rate = 100; m_await = MP_NONE;
  endtask

  task automatic kbd_command(input logic [7:0] c);
    case (c)
      KC_RESET: begin
        post_reply(BYTE_ACK, BYTE_BAT_OK, 0, 0, 2, ORG_KBD);
        kbd_defaults();
      end
      KC_LEDS: begin
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
        pend = PW_LEDS;
      end
      KC_ECHO: post_reply(BYTE_ECHO, 0, 0, 0, 1, ORG_KBD);
      KC_SET: begin
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
        pend = PW_SET;
      end
      KC_RATE: begin
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
        pend = PW_RATE;
      end
      KC_ENABLE: begin
        kscan = 1;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
      end
      KC_DISABLE: begin
        kscan = 0; rep_on = 0;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
      end
      KC_DEFAULTS: begin
        kbd_defaults();
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
      end
      KC_IDENT: post_reply(BYTE_ACK, BYTE_ID1, BYTE_ID2, 0, 3, ORG_KBD);
      KC_RESEND: post_reply(last_byte, 0, 0, 0, 1, ORG_KBD);
      default: post_reply(BYTE_RESEND, 0, 0, 0, 1, ORG_KBD);
    endcase
  endtask

  task automatic aux_command(input logic [7:0] c);
    if (m_await == MP_RATE) begin
      m_await = MP_NONE;
      if (c inside {8'd10, 8'd20, 8'd40, 8'd60, 8'd80, 8'd100, 8'd200}) begin
        m_rate = c;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_AUX);
      end else post_reply(BYTE_RESEND, 0, 0, 0, 1, ORG_AUX);
      return;
    end
    if (m_await == MP_RES) begin
      m_await = MP_NONE;
      if (c <= 3) begin
        m_res = c;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_AUX);
      end else post_reply(BYTE_RESEND, 0, 0, 0, 1, ORG_AUX);
      return;
    end
    case (c)
      MC_RESET: begin
        mouse_defaults();
        post_reply(BYTE_ACK, BYTE_BAT_OK, 0, 0, 3, ORG_AUX);
      end
      MC_DEFAULTS: begin
        mouse_defaults();
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_AUX);
      end
      MC_DISABLE: begin
        m_rep = 0;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_AUX);
      end
      MC_ENABLE: begin
        m_rep = 1;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_AUX);
      end
      MC_IDENT: post_reply(BYTE_ACK, 0, 0, 0, 2, ORG_AUX);
      MC_RATE: begin
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_AUX);
        m_await = MP_RATE;
      end
      MC_RES: begin
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_AUX);
        m_await = MP_RES;
      end
      MC_STATUS: post_reply(BYTE_ACK, {2'b00, m_rep, 2'b00, m_btn}, m_res, m_rate, 4, ORG_AUX);
      default: post_reply(BYTE_RESEND, 0, 0, 0, 1, ORG_AUX);
    endcase
  endtask

  task automatic data_write(input logic [7:0] v);
    case (pend)
      PW_CMDBYTE: begin
        cmd_byte = v; pend = PW_NONE; refresh_irqs();
      end
      PW_OUTPORT: begin
        out_port = v; pend = PW_NONE;
        if (!v[0]) pulse = 1;
      end
      PW_LEDS: begin
        kleds = v & 8'h07; pend = PW_NONE;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
      end
      PW_RATE: begin
        krate = v; pend = PW_NONE;
        post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
      end
      PW_SET: begin
        pend = PW_NONE;
        if (v == 0) post_reply(BYTE_ACK, kset, 0, 0, 2, ORG_KBD);
        else if (v == 1) begin
          kset = 1;
          post_reply(BYTE_ACK, 0, 0, 0, 1, ORG_KBD);
        end else post_reply(BYTE_RESEND, 0, 0, 0, 1, ORG_KBD);
      end
      PW_AUX: begin
        pend = PW_NONE; aux_command(v);
      end
      default: kbd_command(v);
    endcase
  endtask

  task automatic command_write(input logic [7:0] c);
    case (c)
      CC_RD_CB: post_reply(cmd_byte, 0, 0, 0, 1, ORG_CTL);
      CC_WR_CB: pend = PW_CMDBYTE;
      CC_SELFTEST: begin
        sys_flag = 1;
        post_reply(BYTE_SELFOK, 0, 0, 0, 1, ORG_CTL);
      end
      CC_KTEST, CC_ATEST: post_reply(8'h00, 0, 0, 0, 1, ORG_CTL);
      CC_KBD_OFF: begin cmd_byte[4] = 1; refresh_irqs(); end
      CC_KBD_ON: begin cmd_byte[4] = 0; refresh_irqs(); end
      CC_AUX_OFF: begin cmd_byte[5] = 1; refresh_irqs(); end
      CC_AUX_ON: begin cmd_byte[5] = 0; refresh_irqs(); end
      CC_RD_OUTP: post_reply(out_port, 0, 0, 0, 1, ORG_CTL);
      CC_WR_OUTP: pend = PW_OUTPORT;
      CC_WR_AUX: pend = PW_AUX;
      default: ;
    endcase
  endtask

  function automatic logic is_repeating(input logic [7:0] c);
    return !(c inside {8'h1d, 8'h2a, 8'h36, 8'h38, 8'h3a, 8'h45, 8'h46, 8'he0, 8'he1});
  endfunction

  task automatic key_input(input logic [7:0] c, output logic ok);
    ok = 0;
    if (!kbd_en() || !kscan) return;
    if (c[7] && c[6:0] == rep_code[6:0] && rep_code[7] == 1'b0) rep_on = 0;
    else if (typ_delay != 0 && typ_period != 0 && !c[7] && is_repeating(c)) begin
      rep_code = c; rep_count = typ_delay; rep_on = 1;
    end
    ok = fill < FDEPTH;
    fifo_push(c, ORG_KBD);
  endtask

  function automatic logic [7:0] sat_axis(input logic signed [15:0] d,
                                         input logic [7:0] sgn, ovf,
                                         inout logic [7:0] first);
    if (d > 255) begin
      first |= ovf;
      return 8'hff;
    end
    if (d < -256) begin
      first |= sgn | ovf;
      return 8'h00;
    end
    if (d < 0) first |= sgn;
    return d[7:0];
  endfunction

  task automatic mouse_report(input ps2kmc_in_t it, output logic ok);
    logic [7:0] p0, p1, p2;
    ok = 0;
    if (!aux_en() || !m_rep) return;
    if (it.delta_x == 0 && it.delta_y == 0 && it.buttons == m_btn) begin
      ok = 1;
      return;
    end
    if (rlen != 0 || FDEPTH - fill < 3) return;
    p0 = {5'b00001, it.buttons};
    p1 = sat_axis(it.delta_x, 8'h10, 8'h40, p0);
    p2 = sat_axis(it.delta_y, 8'h20, 8'h80, p0);
    fifo_push(p0, ORG_AUX);
    fifo_push(p1, ORG_AUX);
    fifo_push(p2, ORG_AUX);
    m_btn = it.buttons;
    ok = 1;
  endtask

  task automatic predict_result(input ps2kmc_in_t it);
    ps2kmc_out_t r;
    logic ok;
    r = '0;
    pulse = 0;
    case (it.op)
      OP_RD_DATA: fifo_pop(r.read_data);
      OP_RD_STATUS: r.read_data = {2'b00, fill != 0 && fifo_org[head] == ORG_AUX,
                                   kbd_en(), 1'b0, sys_flag, 1'b0, fill != 0};
      OP_WR_DATA: data_write(it.data_byte);
      OP_WR_CMD: command_write(it.data_byte);
      OP_TICK: elapse(it.tick_count);
      OP_SCAN: begin key_input(it.data_byte, ok); r.result_status = !ok; end
      OP_MOUSE: begin mouse_report(it, ok); r.result_status = !ok; end
      default: ;
    endcase
    r.irq1_level = irq1;
    r.irq12_level = irq12;
    r.a20_enable = out_port[1];
    r.cpu_reset_request = pulse;
    expected_results.push_back(r);
  endtask

  task automatic reset_shadow();
    typ_delay = 0; typ_period = 0; rep_delay = 0;
    head = 0; fill = 0; rlen = 0; rorg = ORG_KBD; rwait = 0;
    cmd_byte = 8'h07; out_port = 8'h01; pend = PW_NONE;
    rep_code = 0;
    kbd_defaults();
    mouse_defaults();
    sys_flag = 1; irq1 = 0; irq12 = 0; last_byte = 0; pulse = 0;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: offers queued items; valid stays high across back-to-back transfers.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_result(in_data);
        transfers_in++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap = gap_len();
        end else in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  int out_gap = 0;
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) out_gap = gap_len();
    end
  end

  always @(posedge clk) begin
    ps2kmc_out_t e;
    if (!rst && out_valid && !out_stall) begin
      transfers_out++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", e, out_data);
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic ps2kmc_in_t make_item(input op_t op, input logic [7:0] d);
    ps2kmc_in_t it;
    it.op = op;
    it.data_byte = d;
    it.tick_count = $urandom_range(0, 30);
    it.delta_x = $urandom;
    it.delta_y = $urandom;
    it.buttons = $urandom;
    return it;
  endfunction

  task automatic add(input op_t op, input logic [7:0] d);
    pending_items.push_back(make_item(op, d));
  endtask

  task automatic add_tick(input logic [23:0] n);
    ps2kmc_in_t it;
    it = make_item(OP_TICK, 8'h00);
    it.tick_count = n;
    pending_items.push_back(it);
  endtask

  task automatic add_mouse(input logic signed [15:0] dx, dy, input logic [2:0] b);
    ps2kmc_in_t it;
    it = make_item(OP_MOUSE, 8'h00);
    it.delta_x = dx; it.delta_y = dy; it.buttons = b;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] v);
    @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr <= 1'b0;
    case (idx)
      CFG_TYP_DELAY: typ_delay = v;
      CFG_TYP_PERIOD: typ_period = v;
      CFG_REPLY_DLY: rep_delay = v;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_byte(input int cls);
    logic [7:0] kc [13] = '{8'hff, 8'hed, 8'hee, 8'hf0, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
                            8'hf2, 8'hfe, 8'h00, 8'h01, 8'h12};
    logic [7:0] mc [12] = '{8'hff, 8'hf6, 8'hf5, 8'hf4, 8'hf2, 8'hf3, 8'he8, 8'he9,
                            8'd10, 8'd200, 8'd3, 8'h77};
    logic [7:0] cc [13] = '{8'h20, 8'h60, 8'haa, 8'hab, 8'had, 8'hae, 8'ha7, 8'ha8,
                            8'ha9, 8'hd0, 8'hd1, 8'hd4, 8'h42};
    if ($urandom_range(0, 9) == 0) return $urandom;
    case (cls)
      0: return kc[$urandom_range(0, 12)];
      1: return mc[$urandom_range(0, 11)];
      default: return cc[$urandom_range(0, 12)];
    endcase
  endfunction

  task automatic random_item();
    int p;
    logic signed [15:0] dx, dy;
    p = $urandom_range(0, 99);
    if (p < 22) add(OP_RD_DATA, 0);
    else if (p < 27) add(OP_RD_STATUS, 0);
    else if (p < 37) add(OP_WR_DATA, pick_byte(0));
    else if (p < 45) begin
      add(OP_WR_CMD, CC_WR_AUX);
      add(OP_WR_DATA, pick_byte(1));
    end else if (p < 55) add(OP_WR_CMD, pick_byte(2));
    else if (p < 57) begin
      add(OP_WR_CMD, CC_WR_CB);
      add(OP_WR_DATA, $urandom_range(0, 3) == 0 ? $urandom : 8'h07 ^ ($urandom & 8'h03));
    end else if (p < 58) begin
      add(OP_WR_CMD, CC_WR_OUTP);
      add(OP_WR_DATA, $urandom);
    end else if (p < 70) add_tick($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 60));
    else if (p < 85) add(OP_SCAN, $urandom);
    else begin
      dx = ($urandom_range(0, 4) == 0) ? $urandom : $signed($urandom_range(0, 600)) - 300;
      dy = ($urandom_range(0, 4) == 0) ? $urandom : $signed($urandom_range(0, 600)) - 300;
      if ($urandom_range(0, 7) == 0) begin dx = 0; dy = 0; end
      add_mouse(dx, dy, $urandom);
    end
  endtask

  initial begin
    reset_shadow();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: command set, replies, mouse saturation, pulses, empty read.
    write_reg(CFG_TYP_DELAY, 24'd5);
    write_reg(CFG_TYP_PERIOD, 24'd3);
    write_reg(CFG_REPLY_DLY, 24'd0);
    add(OP_RD_DATA, 0);
    add(OP_RD_STATUS, 0);
    add(OP_WR_DATA, KC_IDENT);
    add(OP_WR_DATA, KC_ECHO);
    add(OP_RD_DATA, 0); add(OP_RD_DATA, 0); add(OP_RD_DATA, 0);
    add(OP_WR_CMD, CC_WR_AUX); add(OP_WR_DATA, MC_ENABLE);
    add(OP_RD_DATA, 0);
    add(OP_WR_CMD, CC_AUX_ON);
    add_mouse(16'sh7fff, -16'sh8000, 3'd7);
    add_mouse(16'sd0, 16'sd0, 3'd7);
    add_mouse(-16'sd5, 16'sd255, 3'd0);
    add(OP_RD_STATUS, 0);
    add(OP_SCAN, 8'h1e);
    add_tick(24'd40);
    add(OP_SCAN, 8'h9e);
    add(OP_WR_CMD, CC_WR_OUTP); add(OP_WR_DATA, 8'h00);
    add(OP_WR_CMD, CC_WR_OUTP); add(OP_WR_DATA, 8'hff);
    add(OP_WR_CMD, 8'h07);
    add_tick(24'hffffff);
    drain();

    // Pressure: hold the receiver off while the sender keeps going.
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) add(OP_RD_STATUS, 0);
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_TYP_DELAY, 24'd0); write_reg(CFG_TYP_PERIOD, 24'd0);
          write_reg(CFG_REPLY_DLY, 24'd0);
        end
        1: begin
          write_reg(CFG_TYP_DELAY, 24'd10); write_reg(CFG_TYP_PERIOD, 24'd4);
          write_reg(CFG_REPLY_DLY, 24'd6);
        end
        2: begin
          write_reg(CFG_TYP_DELAY, 24'hffffff); write_reg(CFG_TYP_PERIOD, 24'hffffff);
          write_reg(CFG_REPLY_DLY, 24'hffffff);
        end
        3: begin
          write_reg(CFG_TYP_DELAY, 24'd1); write_reg(CFG_TYP_PERIOD, 24'd1);
          write_reg(CFG_REPLY_DLY, 24'd1);
        end
        4: begin
          write_reg(CFG_TYP_DELAY, 24'd3); write_reg(CFG_TYP_PERIOD, 24'd7);
          write_reg(CFG_REPLY_DLY, 24'd0);
          add(OP_SCAN, 8'h10);
          drain();
          write_reg(CFG_TYP_PERIOD, 24'd0);
        end
        default: begin
          write_reg(CFG_TYP_DELAY, $urandom_range(1, 50));
          write_reg(CFG_TYP_PERIOD, $urandom_range(1, 20));
          write_reg(CFG_REPLY_DLY, $urandom_range(0, 20));
        end
      endcase
      for (int i = 0; i < 225; i++) random_item();
      drain();
    end

    $display("Covered %0d transfers in and %0d out over six register settings,",
             transfers_in, transfers_out);
    $display("with keyboard, mouse and controller commands, repeat and stalls.");
    if (mismatches == 0 && expected_results.size() == 0) $display("Regression PASS");
    else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/ps2kmc_pkg.sv
design/ps2kmc_ctrl.sv
design/ps2kmc_dp.sv
design/ps2_keyboard_mouse_controller.sv
sim/ps2_keyboard_mouse_controller_test.sv
